[hw/rtl/sdqr_pkg.sv]
// package for the signed divider: shared sideband types and defaults
// used by every module of the signed_divide_quot_rem block
`default_nettype none

package sdqr_pkg;

  // default operand width
  localparam int unsigned SdqrWidth = 32;

  // sideband carried alongside each transaction through the pipeline
  typedef struct packed {
    logic num_neg;   // numerator was negative, remainder gets negated
    logic quo_neg;   // quotient gets negated
    logic div_zero;  // denominator was zero
    logic ovf;       // most negative value divided by minus one
  } sdqr_flags_t;

endpackage

`default_nettype wire

[hw/rtl/sdqr_prep.sv]
// input stage: takes operand magnitudes and flags the special cases
// depends on sdqr_pkg
`default_nettype none

module sdqr_prep #(
  parameter int unsigned WIDTH = sdqr_pkg::SdqrWidth
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire                       valid_i,
  input  wire  [WIDTH-1:0]          numerator_i,
  input  wire  [WIDTH-1:0]          denominator_i,
  output logic                      valid_o,
  output logic [WIDTH-1:0]          mag_num_o,
  output logic [WIDTH-1:0]          mag_den_o,
  output sdqr_pkg::sdqr_flags_t     flags_o
);
  import sdqr_pkg::*;

  localparam logic [WIDTH-1:0] One    = WIDTH'(1);
  localparam logic [WIDTH-1:0] MinVal = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] AllOne = {WIDTH{1'b1}};

  logic              n_neg, d_neg;
  logic [WIDTH-1:0]  mag_num_d, mag_den_d;
  sdqr_flags_t       flags_d;
  logic              valid_q;
  logic [WIDTH-1:0]  mag_num_q, mag_den_q;
  sdqr_flags_t       flags_q;

  // absolute values and special-case detection
  always_comb begin
    n_neg            = numerator_i[WIDTH-1];
    d_neg            = denominator_i[WIDTH-1];
    mag_num_d        = n_neg ? (~numerator_i + One) : numerator_i;
    mag_den_d        = d_neg ? (~denominator_i + One) : denominator_i;
    flags_d.div_zero = (denominator_i == '0);
    flags_d.ovf      = (numerator_i == MinVal) && (denominator_i == AllOne);
    flags_d.num_neg  = n_neg;
    flags_d.quo_neg  = (n_neg ^ d_neg) && !flags_d.div_zero;
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_num_q <= mag_num_d;
      mag_den_q <= mag_den_d;
      flags_q   <= flags_d;
    end
  end

  assign valid_o   = valid_q;
  assign mag_num_o = mag_num_q;
  assign mag_den_o = mag_den_q;
  assign flags_o   = flags_q;

endmodule

`default_nettype wire

[hw/rtl/sdqr_step.sv]
// one restoring-division stage: retires one quotient bit per transaction
// depends on sdqr_pkg
`default_nettype none

module sdqr_step #(
  parameter int unsigned WIDTH = sdqr_pkg::SdqrWidth
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire                       valid_i,
  input  wire  [WIDTH-1:0]          rem_i,
  input  wire  [WIDTH-1:0]          quo_i,
  input  wire  [WIDTH-1:0]          den_i,
  input  wire  sdqr_pkg::sdqr_flags_t flags_i,
  output logic                      valid_o,
  output logic [WIDTH-1:0]          rem_o,
  output logic [WIDTH-1:0]          quo_o,
  output logic [WIDTH-1:0]          den_o,
  output sdqr_pkg::sdqr_flags_t     flags_o
);
  import sdqr_pkg::*;

  logic [WIDTH-1:0] rem_sh;
  logic [WIDTH:0]   trial;
  logic [WIDTH-1:0] rem_d, quo_d;
  logic             valid_q;
  logic [WIDTH-1:0] rem_q, quo_q, den_q;
  sdqr_flags_t      flags_q;

  // shift in the next numerator bit and try subtracting the divisor
  always_comb begin
    rem_sh = {rem_i[WIDTH-2:0], quo_i[WIDTH-1]};
    trial  = {1'b0, rem_sh} - {1'b0, den_i};
    rem_d  = trial[WIDTH] ? rem_sh : trial[WIDTH-1:0];
    quo_d  = {quo_i[WIDTH-2:0], ~trial[WIDTH]};
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      den_q   <= den_i;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

[hw/rtl/sdqr_finish.sv]
// output stage: restores signs and drives the result register
// depends on sdqr_pkg
`default_nettype none

module sdqr_finish #(
  parameter int unsigned WIDTH = sdqr_pkg::SdqrWidth
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire                       valid_i,
  input  wire  [WIDTH-1:0]          quo_i,
  input  wire  [WIDTH-1:0]          rem_i,
  input  wire  sdqr_pkg::sdqr_flags_t flags_i,
  output logic                      valid_o,
  output logic [WIDTH-1:0]          quotient_o,
  output logic [WIDTH-1:0]          remainder_o,
  output logic                      divide_by_zero_o,
  output logic                      overflow_o
);
  import sdqr_pkg::*;

  localparam logic [WIDTH-1:0] One = WIDTH'(1);

  logic [WIDTH-1:0] quo_d, rem_d;
  logic             valid_q;
  logic [WIDTH-1:0] quo_q, rem_q;
  logic             dz_q, ovf_q;

  // sign restore; a zero divisor already leaves all ones and the numerator magnitude
  always_comb begin
    quo_d = flags_i.quo_neg ? (~quo_i + One) : quo_i;
    rem_d = flags_i.num_neg ? (~rem_i + One) : rem_i;
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      dz_q  <= flags_i.div_zero;
      ovf_q <= flags_i.ovf;
    end
  end

  assign valid_o          = valid_q;
  assign quotient_o       = quo_q;
  assign remainder_o      = rem_q;
  assign divide_by_zero_o = dz_q;
  assign overflow_o       = ovf_q;

endmodule

`default_nettype wire

[hw/rtl/signed_divide_quot_rem.sv]
// signed divider, quotient truncated toward zero, remainder signed as the numerator
// pipeline: one input stage, one stage per quotient bit, one output stage
// throughput: one transaction per cycle; the whole pipeline holds while the result is stalled
// reset: asynchronous active-low, clears all valid bits; payload registers are not reset
// depends on sdqr_pkg, sdqr_prep, sdqr_step, sdqr_finish
`default_nettype none

module signed_divide_quot_rem #(
  parameter int unsigned WIDTH = sdqr_pkg::SdqrWidth
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [WIDTH-1:0]  numerator_i,
  input  wire  [WIDTH-1:0]  denominator_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [WIDTH-1:0]  quotient_o,
  output logic [WIDTH-1:0]  remainder_o,
  output logic              divide_by_zero_o,
  output logic              overflow_o
);
  import sdqr_pkg::*;

  localparam logic [WIDTH-1:0] MinVal = {1'b1, {(WIDTH-1){1'b0}}};

  logic             en;
  logic             vld_pipe [0:WIDTH];
  logic [WIDTH-1:0] rem_pipe [0:WIDTH];
  logic [WIDTH-1:0] quo_pipe [0:WIDTH];
  logic [WIDTH-1:0] den_pipe [0:WIDTH];
  sdqr_flags_t      flg_pipe [0:WIDTH];

  // pipeline advances unless the result register is full and stalled
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // magnitudes and flags
  sdqr_prep #(.WIDTH(WIDTH)) u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_valid_i),
    .numerator_i   (numerator_i),
    .denominator_i (denominator_i),
    .valid_o       (vld_pipe[0]),
    .mag_num_o     (quo_pipe[0]),
    .mag_den_o     (den_pipe[0]),
    .flags_o       (flg_pipe[0])
  );

  assign rem_pipe[0] = '0;

  // one stage per quotient bit
  for (genvar gi = 0; gi < WIDTH; gi++) begin : g_step
    sdqr_step #(.WIDTH(WIDTH)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld_pipe[gi]),
      .rem_i   (rem_pipe[gi]),
      .quo_i   (quo_pipe[gi]),
      .den_i   (den_pipe[gi]),
      .flags_i (flg_pipe[gi]),
      .valid_o (vld_pipe[gi+1]),
      .rem_o   (rem_pipe[gi+1]),
      .quo_o   (quo_pipe[gi+1]),
      .den_o   (den_pipe[gi+1]),
      .flags_o (flg_pipe[gi+1])
    );
  end

  // sign restore and result register
  sdqr_finish #(.WIDTH(WIDTH)) u_finish (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .valid_i          (vld_pipe[WIDTH]),
    .quo_i            (quo_pipe[WIDTH]),
    .rem_i            (rem_pipe[WIDTH]),
    .flags_i          (flg_pipe[WIDTH]),
    .valid_o          (out_valid_o),
    .quotient_o       (quotient_o),
    .remainder_o      (remainder_o),
    .divide_by_zero_o (divide_by_zero_o),
    .overflow_o       (overflow_o)
  );

  // divide by zero gives all-ones quotient and never overflow
  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> (quotient_o == '1) && !overflow_o)
    else $error("divide by zero result malformed");

  // overflow wraps to the most negative value with zero remainder
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> (quotient_o == MinVal) && (remainder_o == '0))
    else $error("overflow result malformed");

  // input is held off only while a finished result is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // remainder magnitude stays below divisor magnitude at the last step
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_pipe[WIDTH] && !flg_pipe[WIDTH].div_zero |-> rem_pipe[WIDTH] < den_pipe[WIDTH])
    else $error("remainder not below divisor");

endmodule

`default_nettype wire
